// ===== rtl/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared widths, constants and inter-stage types of the GTF timing core.
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int WW      = 12;  // active width
  localparam int HW      = 12;  // active height
  localparam int FW      = 8;   // refresh rate
  localparam int KW      = 12;  // 11 * refresh
  localparam int VBLW    = 13;  // vertical total
  localparam int VFW     = 21;  // line rate in Hz
  localparam int HBLW    = 11;  // horizontal blank width
  localparam int PosW    = 16;
  localparam int ClkW    = 22;

  // vertical total divider
  localparam int VQ_BITS = 11;
  localparam int VNUM_W  = 25;
  localparam int VDEN_W  = 16;
  localparam int VCMP_W  = VNUM_W + 2;

  // horizontal blank divider
  localparam int HQ_BITS = 7;
  localparam int HNUM_W  = 39;
  localparam int HDEN_W  = 32;
  localparam int HCMP_W  = HNUM_W + 1;
  localparam int HPROD_W = 40;
  localparam int HT_W    = 27;

  localparam int VTOT_K   = 20000;
  localparam int HOFF_K   = 300000;
  // floor(x/100) = (x * DIV100_M) >> 20 for x < 2^13
  localparam int DIV100_M = 10486;
  localparam int DIV100_S = 20;
  // floor(n/125) = (n * DIV125_M) >> 37 for n < 2^31
  localparam longint DIV125_M = 64'd1099511628;
  localparam int DIV125_S = 37;
  localparam int CLK_MAX  = 4194303;

  typedef struct packed {
    logic [WW-1:0]   w;
    logic [HW-1:0]   h;
    logic [VBLW-1:0] vbl;
    logic [VFW-1:0]  vfreq;
  } vt_t;

  typedef struct packed {
    logic [WW-1:0]   w;
    logic [HW-1:0]   h;
    logic [VBLW-1:0] vbl;
    logic [VFW-1:0]  vfreq;
    logic [HBLW-1:0] hbl;
  } hz_t;

endpackage

// ===== rtl/gtc_vert.sv =====
// ----------------------------------------------------------------------------
// gtc_vert
// Vertical total and line rate: numerator/denominator setup, restoring
// divider one quotient bit per stage, then total and line-rate multiply.
// ----------------------------------------------------------------------------
module gtc_vert import gtc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  input  logic [FW-1:0] refresh_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vt_t           out_o
);

  localparam int NS = VQ_BITS + 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
    v_d = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_d[i];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 0
  logic [WW-1:0]   w0_q;
  logic [HW-1:0]   h0_q;
  logic [FW-1:0]   f0_q;
  logic [KW-1:0]   k0_q;
  logic [VBLW-1:0] hp0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      w0_q  <= width_i;
      h0_q  <= height_i;
      f0_q  <= refresh_i;
      k0_q  <= KW'(refresh_i) * KW'(11);
      hp0_q <= VBLW'(height_i) + VBLW'(1);
    end
  end

  // stage 1: vnum = 2(h+1)k + 3(20000-k), vden = 2(20000-k)
  logic [14:0]       diff;
  logic [VNUM_W-1:0] vnum_d;

  always_comb begin
    diff   = 15'(VTOT_K) - 15'(k0_q);
    vnum_d = ((VNUM_W'(hp0_q) * VNUM_W'(k0_q)) << 1) + VNUM_W'(diff) * VNUM_W'(3);
  end

  logic [VNUM_W-1:0]  rem_q [VQ_BITS];
  logic [VDEN_W-1:0]  den_q [VQ_BITS];
  logic [VQ_BITS-1:0] q_q   [VQ_BITS+1];
  logic [WW-1:0]      w_q   [VQ_BITS+1];
  logic [HW-1:0]      h_q   [VQ_BITS+1];
  logic [FW-1:0]      f_q   [VQ_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rem_q[0] <= vnum_d;
      den_q[0] <= {diff, 1'b0};
      q_q[0]   <= '0;
      w_q[0]   <= w0_q;
      h_q[0]   <= h0_q;
      f_q[0]   <= f0_q;
    end
  end

  for (genvar d = 0; d < VQ_BITS; d++) begin : g_div
    logic [VCMP_W-1:0] sd;
    logic              take;

    always_comb begin
      sd   = VCMP_W'(den_q[d]) << (VQ_BITS - 1 - d);
      take = (VCMP_W'(rem_q[d]) >= sd);
    end

    always_ff @(posedge clk_i) begin
      if (en[d+2]) begin
        q_q[d+1] <= {q_q[d][VQ_BITS-2:0], take};
        w_q[d+1] <= w_q[d];
        h_q[d+1] <= h_q[d];
        f_q[d+1] <= f_q[d];
      end
    end

    if (d < VQ_BITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en[d+2]) begin
          rem_q[d+1] <= take ? rem_q[d] - sd[VNUM_W-1:0] : rem_q[d];
          den_q[d+1] <= den_q[d];
        end
      end
    end
  end

  // vertical total
  logic [VBLW-1:0] vbl_q;
  logic [WW-1:0]   wv_q;
  logic [HW-1:0]   hv_q;
  logic [FW-1:0]   fv_q;

  always_ff @(posedge clk_i) begin
    if (en[VQ_BITS+2]) begin
      vbl_q <= VBLW'(h_q[VQ_BITS]) + VBLW'(q_q[VQ_BITS]);
      wv_q  <= w_q[VQ_BITS];
      hv_q  <= h_q[VQ_BITS];
      fv_q  <= f_q[VQ_BITS];
    end
  end

  // line rate
  vt_t res_q;

  always_ff @(posedge clk_i) begin
    if (en[VQ_BITS+3]) begin
      res_q.w     <= wv_q;
      res_q.h     <= hv_q;
      res_q.vbl   <= vbl_q;
      res_q.vfreq <= VFW'(vbl_q) * VFW'(fv_q);
    end
  end

  assign out_o = res_q;

endmodule

// ===== rtl/gtc_horiz.sv =====
// ----------------------------------------------------------------------------
// gtc_horiz
// Horizontal blank width: signed numerator and denominator setup, then a
// restoring divider one quotient bit per stage. Non-positive numerator
// gives a zero blank.
// ----------------------------------------------------------------------------
module gtc_horiz import gtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  vt_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output hz_t  out_o
);

  localparam int NS = HQ_BITS + 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
    v_d = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_d[i];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 0: 30*vfreq - 300000 and 70*vfreq + 300000
  logic signed [HT_W-1:0] t30_q;
  logic [HT_W-1:0]        e0_q;
  vt_t                    c0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t30_q <= $signed(HT_W'(HT_W'(in_i.vfreq) * HT_W'(30))) - $signed(HT_W'(HOFF_K));
      e0_q  <= HT_W'(in_i.vfreq) * HT_W'(70) + HT_W'(HOFF_K);
      c0_q  <= in_i;
    end
  end

  // stage 1: 2w * (30 vfreq - 300000)
  logic signed [WW+1:0]      w2;
  logic signed [HPROD_W-1:0] prod_d;
  logic signed [HPROD_W-1:0] prod_q;
  logic [HT_W-1:0]           e1_q;
  logic [HDEN_W-1:0]         den1_q;
  vt_t                       c1_q;

  always_comb begin
    w2     = $signed({1'b0, c0_q.w, 1'b0});
    prod_d = w2 * t30_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_q <= prod_d;
      e1_q   <= e0_q;
      den1_q <= {e0_q, 5'b0};
      c1_q   <= c0_q;
    end
  end

  // stage 2: numerator, clamp non-positive to zero
  logic signed [HPROD_W-1:0] hnum_d;
  logic [HNUM_W-1:0]         num_d;

  always_comb begin
    hnum_d = prod_q + $signed({{(HPROD_W-HT_W-4){1'b0}}, e1_q, 4'b0});
    num_d  = (hnum_d > 0) ? hnum_d[HNUM_W-1:0] : '0;
  end

  logic [HNUM_W-1:0]  rem_q [HQ_BITS];
  logic [HDEN_W-1:0]  den_q [HQ_BITS];
  logic [HQ_BITS-1:0] q_q   [HQ_BITS+1];
  vt_t                c_q   [HQ_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rem_q[0] <= num_d;
      den_q[0] <= den1_q;
      q_q[0]   <= '0;
      c_q[0]   <= c1_q;
    end
  end

  for (genvar d = 0; d < HQ_BITS; d++) begin : g_div
    logic [HCMP_W-1:0] sd;
    logic              take;

    always_comb begin
      sd   = HCMP_W'(den_q[d]) << (HQ_BITS - 1 - d);
      take = (HCMP_W'(rem_q[d]) >= sd);
    end

    always_ff @(posedge clk_i) begin
      if (en[d+3]) begin
        q_q[d+1] <= {q_q[d][HQ_BITS-2:0], take};
        c_q[d+1] <= c_q[d];
      end
    end

    if (d < HQ_BITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en[d+3]) begin
          rem_q[d+1] <= take ? rem_q[d] - sd[HNUM_W-1:0] : rem_q[d];
          den_q[d+1] <= den_q[d];
        end
      end
    end
  end

  hz_t res_q;

  always_ff @(posedge clk_i) begin
    if (en[HQ_BITS+3]) begin
      res_q.w     <= c_q[HQ_BITS].w;
      res_q.h     <= c_q[HQ_BITS].h;
      res_q.vbl   <= c_q[HQ_BITS].vbl;
      res_q.vfreq <= c_q[HQ_BITS].vfreq;
      res_q.hbl   <= {q_q[HQ_BITS], 4'b0};
    end
  end

  assign out_o = res_q;

endmodule

// ===== rtl/gtc_out.sv =====
// ----------------------------------------------------------------------------
// gtc_out
// Sync and blank positions and the pixel clock: line length times line
// rate, divided by 1000 through a reciprocal multiply, then saturated.
// ----------------------------------------------------------------------------
module gtc_out import gtc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hz_t             in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ClkW-1:0] pixel_clock_khz_o,
  output logic [PosW-1:0] hsync_begin_o,
  output logic [PosW-1:0] hsync_finish_o,
  output logic [PosW-1:0] hblank_end_o,
  output logic [PosW-1:0] vsync_begin_o,
  output logic [PosW-1:0] vsync_finish_o,
  output logic [PosW-1:0] vblank_end_o
);

  localparam int NS   = 4;
  localparam int TOTW = 13;
  localparam int PW   = 34;
  localparam int NW   = PW - 3;
  localparam int MW   = 2 * NW;
  localparam int D1W  = TOTW + 14;
  localparam int QW   = MW - DIV125_S;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
    v_d = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_d[i];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 0: line length and positions
  logic [TOTW-1:0] tot_q;
  logic [VFW-1:0]  vf0_q;
  logic [PosW-1:0] hse0_q, hbe0_q, vsb0_q, vsf0_q, vbe0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tot_q  <= TOTW'(in_i.w) + TOTW'(in_i.hbl);
      vf0_q  <= in_i.vfreq;
      hse0_q <= PosW'(in_i.w) + PosW'(in_i.hbl >> 1) - PosW'(1);
      hbe0_q <= PosW'(in_i.w) + PosW'(in_i.hbl) - PosW'(1);
      vsb0_q <= PosW'(in_i.h);
      vsf0_q <= PosW'(in_i.h) + PosW'(3);
      vbe0_q <= PosW'(in_i.vbl) - PosW'(1);
    end
  end

  // stage 1: clock product, (tot + 50) / 100
  logic [TOTW-1:0] x50;
  logic [D1W-1:0]  d1_prod;
  logic [PW-1:0]   p_q;
  logic [6:0]      d100_q;
  logic [PosW-1:0] hse1_q, hbe1_q, vsb1_q, vsf1_q, vbe1_q;

  always_comb begin
    x50     = tot_q + TOTW'(50);
    d1_prod = D1W'(x50) * D1W'(DIV100_M);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_q    <= PW'(tot_q) * PW'(vf0_q);
      d100_q <= d1_prod[DIV100_S+6:DIV100_S];
      hse1_q <= hse0_q;
      hbe1_q <= hbe0_q;
      vsb1_q <= vsb0_q;
      vsf1_q <= vsf0_q;
      vbe1_q <= vbe0_q;
    end
  end

  // stage 2: (p / 8) * reciprocal of 125
  logic [MW-1:0]   m_q;
  logic [PosW-1:0] hsb2_q, hse2_q, hbe2_q, vsb2_q, vsf2_q, vbe2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      m_q    <= MW'(p_q[PW-1:3]) * MW'(DIV125_M);
      hsb2_q <= hse1_q - PosW'({d100_q, 3'b0});
      hse2_q <= hse1_q;
      hbe2_q <= hbe1_q;
      vsb2_q <= vsb1_q;
      vsf2_q <= vsf1_q;
      vbe2_q <= vbe1_q;
    end
  end

  // stage 3: output register with saturation
  logic [QW-1:0]   clk_full;
  logic [ClkW-1:0] clk_d;

  always_comb begin
    clk_full = m_q[MW-1:DIV125_S];
    clk_d    = (clk_full > QW'(CLK_MAX)) ? ClkW'(CLK_MAX) : clk_full[ClkW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pixel_clock_khz_o <= clk_d;
      hsync_begin_o     <= hsb2_q;
      hsync_finish_o    <= hse2_q;
      hblank_end_o      <= hbe2_q;
      vsync_begin_o     <= vsb2_q;
      vsync_finish_o    <= vsf2_q;
      vblank_end_o      <= vbe2_q;
    end
  end

endmodule

// ===== rtl/gtf_mode_timing_calc_core.sv =====
// ----------------------------------------------------------------------------
// gtf_mode_timing_calc_core
// Simplified GTF mode timing calculator, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one transaction (width, height, refresh) per clock while the output
// side is not stalled, and returns one result per transaction in order
// after 15 stages for the vertical total (an 11-stage bit-per-stage
// divider), 11 for the horizontal blank (a 7-stage divider) and 4 for
// positions and pixel clock. Each stage holds independently, so bubbles
// are squeezed out during an output stall. No state is kept between
// transactions; reset only clears the valid bits.
module gtf_mode_timing_calc_core import gtc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [WW-1:0]   width_i,
  input  logic [HW-1:0]   height_i,
  input  logic [FW-1:0]   refresh_hz_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ClkW-1:0] pixel_clock_khz_o,
  output logic [PosW-1:0] hsync_begin_o,
  output logic [PosW-1:0] hsync_finish_o,
  output logic [PosW-1:0] hblank_end_o,
  output logic [PosW-1:0] vsync_begin_o,
  output logic [PosW-1:0] vsync_finish_o,
  output logic [PosW-1:0] vblank_end_o
);

  logic vt_valid, vt_ready;
  logic hz_valid, hz_ready;
  vt_t  vt;
  hz_t  hz;

  gtc_vert u_vert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .width_i     (width_i),
    .height_i    (height_i),
    .refresh_i   (refresh_hz_i),
    .out_valid_o (vt_valid),
    .out_ready_i (vt_ready),
    .out_o       (vt)
  );

  gtc_horiz u_horiz (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vt_valid),
    .in_ready_o  (vt_ready),
    .in_i        (vt),
    .out_valid_o (hz_valid),
    .out_ready_i (hz_ready),
    .out_o       (hz)
  );

  gtc_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (hz_valid),
    .in_ready_o        (hz_ready),
    .in_i              (hz),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pixel_clock_khz_o (pixel_clock_khz_o),
    .hsync_begin_o     (hsync_begin_o),
    .hsync_finish_o    (hsync_finish_o),
    .hblank_end_o      (hblank_end_o),
    .vsync_begin_o     (vsync_begin_o),
    .vsync_finish_o    (vsync_finish_o),
    .vblank_end_o      (vblank_end_o)
  );

endmodule

// ===== tb/gtf_mode_timing_calc_checker.sv =====
// ----------------------------------------------------------------------------
// gtf_mode_timing_calc_checker
// Watches both channels of the GTF timing core, computes the expected mode
// timings for every accepted transaction and compares results in order.
// ----------------------------------------------------------------------------
module gtf_mode_timing_calc_checker import gtc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [WW-1:0]   width_i,
  input  logic [HW-1:0]   height_i,
  input  logic [FW-1:0]   refresh_hz_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [ClkW-1:0] pixel_clock_khz_i,
  input  logic [PosW-1:0] hsync_begin_i,
  input  logic [PosW-1:0] hsync_finish_i,
  input  logic [PosW-1:0] hblank_end_i,
  input  logic [PosW-1:0] vsync_begin_i,
  input  logic [PosW-1:0] vsync_finish_i,
  input  logic [PosW-1:0] vblank_end_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ClkW-1:0] clk;
    logic [PosW-1:0] hs_beg;
    logic [PosW-1:0] hs_end;
    logic [PosW-1:0] hb_end;
    logic [PosW-1:0] vs_beg;
    logic [PosW-1:0] vs_end;
    logic [PosW-1:0] vb_end;
  } timing_t;

  timing_t mode_q[$];
  int fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = mode_q.size();

  function automatic timing_t gtf_timing(logic [WW-1:0] w, logic [HW-1:0] h,
                                         logic [FW-1:0] f);
    longint k, vden, vnum, vbl, vfreq, hden, hnum, hbl, pclk;
    logic [31:0] x32, b32;
    timing_t t;
    k     = 11 * longint'(f);
    vden  = 2 * (VTOT_K - k);
    vnum  = 2 * (longint'(h) + 1) * k + 3 * (VTOT_K - k);
    vbl   = longint'(h) + vnum / vden;
    vfreq = vbl * longint'(f);
    hden  = 32 * (70 * vfreq + HOFF_K);
    hnum  = 2 * longint'(w) * (30 * vfreq - HOFF_K) + 16 * (70 * vfreq + HOFF_K);
    hbl   = (hnum > 0) ? 16 * (hnum / hden) : 0;
    pclk  = ((longint'(w) + hbl) * vfreq) / 1000;
    if (pclk > CLK_MAX) pclk = CLK_MAX;
    x32 = 32'(w);
    b32 = 32'(hbl);
    t.clk    = ClkW'(pclk);
    t.hs_beg = PosW'(x32 + b32 / 2 - ((x32 + b32 + 50) / 100) * 8 - 1);
    t.hs_end = PosW'(x32 + b32 / 2 - 1);
    t.hb_end = PosW'(x32 + b32 - 1);
    t.vs_beg = PosW'(h);
    t.vs_end = PosW'(32'(h) + 3);
    t.vb_end = PosW'(vbl - 1);
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i) begin
    timing_t exp_t, got_t;
    if (rst_ni && in_valid_i && in_ready_i)
      mode_q.push_back(gtf_timing(width_i, height_i, refresh_hz_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      got_t = {pixel_clock_khz_i, hsync_begin_i, hsync_finish_i, hblank_end_i,
               vsync_begin_i, vsync_finish_i, vblank_end_i};
      if (mode_q.size() == 0) begin
        report_mismatch("unexpected result, clock", got_t.clk, 0);
      end else begin
        exp_t = mode_q.pop_front();
        if (got_t.clk != exp_t.clk) report_mismatch("pixel clock", got_t.clk, exp_t.clk);
        if (got_t.hs_beg != exp_t.hs_beg)
          report_mismatch("hsync begin", got_t.hs_beg, exp_t.hs_beg);
        if (got_t.hs_end != exp_t.hs_end)
          report_mismatch("hsync finish", got_t.hs_end, exp_t.hs_end);
        if (got_t.hb_end != exp_t.hb_end)
          report_mismatch("hblank end", got_t.hb_end, exp_t.hb_end);
        if (got_t.vs_beg != exp_t.vs_beg)
          report_mismatch("vsync begin", got_t.vs_beg, exp_t.vs_beg);
        if (got_t.vs_end != exp_t.vs_end)
          report_mismatch("vsync finish", got_t.vs_end, exp_t.vs_end);
        if (got_t.vb_end != exp_t.vb_end)
          report_mismatch("vblank end", got_t.vb_end, exp_t.vb_end);
      end
    end
  end

endmodule

// ===== tb/gtf_mode_timing_calc_core_tb.sv =====
// ----------------------------------------------------------------------------
// gtf_mode_timing_calc_core_tb
// Drives directed and random modes into the GTF timing core with random
// idling and back-pressure; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module gtf_mode_timing_calc_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtc_pkg::*;

  localparam int NumRandom  = 1430;
  localparam int CycleLimit = 400000;

  logic            clk, rst_n;
  logic            in_valid, in_ready, out_valid, out_ready;
  logic [WW-1:0]   width;
  logic [HW-1:0]   height;
  logic [FW-1:0]   refresh;
  logic [ClkW-1:0] pclk_khz;
  logic [PosW-1:0] hs_beg, hs_end, hb_end, vs_beg, vs_end, vb_end;
  int              fail_count, pending, cycle_cnt;
  logic            quiet_recv, hold_recv;

  gtf_mode_timing_calc_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .width_i(width), .height_i(height), .refresh_hz_i(refresh),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pixel_clock_khz_o(pclk_khz), .hsync_begin_o(hs_beg), .hsync_finish_o(hs_end),
    .hblank_end_o(hb_end), .vsync_begin_o(vs_beg), .vsync_finish_o(vs_end),
    .vblank_end_o(vb_end)
  );

  gtf_mode_timing_calc_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .width_i(width), .height_i(height), .refresh_hz_i(refresh),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pixel_clock_khz_i(pclk_khz), .hsync_begin_i(hs_beg), .hsync_finish_i(hs_end),
    .hblank_end_i(hb_end), .vsync_begin_i(vs_beg), .vsync_finish_i(vs_end),
    .vblank_end_i(vb_end), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, except during the quiet stretch or a long hold
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_recv) out_ready <= 1'b0;
      else if (quiet_recv) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 37);
    end
  end

  // one long receiver hold-off while the sender keeps offering
  initial begin
    hold_recv = 1'b0;
    wait (cycle_cnt == 200);
    hold_recv = 1'b1;
    repeat (120) @(posedge clk);
    hold_recv = 1'b0;
  end

  // offer one transaction; idle gaps drawn beforehand unless quiet
  task automatic send_mode(logic [WW-1:0] w, logic [HW-1:0] h, logic [FW-1:0] f,
                           bit idle);
    while (idle && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    width    <= w;
    height   <= h;
    refresh  <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [WW-1:0] dw[12];
    logic [HW-1:0] dh[12];
    logic [FW-1:0] df[12];
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [FW-1:0] f;
    int            sel;
    bit            idle;
    in_valid = 1'b0; width = '0; height = '0; refresh = '0;
    quiet_recv = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, zero refresh and tiny heights (negative blank, position
    // wrap), all-ones fields (clock saturation)
    dw = '{8, 2048, 8, 2048, 1024, 4095, 0, 8, 1920, 4095, 640, 2048};
    dh = '{200, 2048, 2048, 200, 768, 4095, 0, 0, 1080, 0, 480, 2048};
    df = '{50, 240, 50, 240, 60, 255, 0, 255, 144, 0, 1, 0};
    for (int i = 0; i < 12; i++) send_mode(dw[i], dh[i], df[i], 1'b1);

    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        w = WW'($urandom_range(2048, 8));
        h = HW'($urandom_range(2048, 200));
        f = FW'($urandom_range(240, 50));
      end else if (sel < 80) begin
        w = ($urandom_range(1) != 0) ? 12'd8 : 12'd2048;
        h = ($urandom_range(1) != 0) ? 12'd200 : 12'd2048;
        f = ($urandom_range(1) != 0) ? 8'd50 : 8'd240;
      end else begin
        w = WW'($urandom);
        h = HW'($urandom);
        f = FW'($urandom);
      end
      // no-idle stretch on both sides
      idle = !(i >= 600 && i < 800);
      quiet_recv = !idle;
      send_mode(w, h, f, idle);
      if (i == 1000) begin
        // drain completely before resuming; sample away from the rising edge
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
